>>> rtl/core/fsre_pkg.sv
// ----------------------------------------------------------------------------
// fsre_pkg
// Shared constants, codes and types of the frame scale and rotate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fsre_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   localparam int SIZE_W   = 9;
   localparam int MODE_W   = 3;
   localparam int PIXEL_W  = 24;
   localparam int COORD_W  = 8;
   localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int FRAME_W  = 2 * SIZE_W;
   localparam int CSR_IDX_W = 3;

   // divider geometry: dividend is coordinate times size
   localparam int DIVIDEND_W = COORD_W + SIZE_W - 1;
   localparam int DIVISOR_W  = SIZE_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFORM     = 3'd4;

   // transform modes
   localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TURN_A    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TURN_B    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MIRROR_LR = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MIRROR_UD = 3'd4;

   // commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] max_v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > max_v) r = max_v;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/fsre_divider.sv
// ----------------------------------------------------------------------------
// fsre_divider
// Restoring divider, one quotient bit per cycle, shared by row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module fsre_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  fsre_pkg::div_req_type req,
   output fsre_pkg::div_rsp_type rsp
);

   logic [fsre_pkg::DIVISOR_W:0]    rem_ff, rem_in;
   logic [fsre_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [fsre_pkg::DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [fsre_pkg::DIV_CNT_W-1:0]  count_ff, count_in;
   logic                            active_ff, active_in;
   logic                            done_ff, done_in;

   logic [fsre_pkg::DIVISOR_W:0] trial;
   logic                         fits;

   assign trial = {rem_ff[fsre_pkg::DIVISOR_W-1:0], quo_ff[fsre_pkg::DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
         count_in   = fsre_pkg::DIV_CNT_W'(fsre_pkg::DIVIDEND_W - 1);
         active_in  = 1'b1;
      end else if (active_ff) begin
         // shift in next dividend bit, subtract when it fits
         rem_in = fits ? (trial - {1'b0, divisor_ff}) : trial;
         quo_in = {quo_ff[fsre_pkg::DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/fsre_frame_store.sv
// ----------------------------------------------------------------------------
// fsre_frame_store
// Source frame memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fsre_frame_store (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire [fsre_pkg::ADDR_W-1:0]       wr_addr,
   input  wire [fsre_pkg::PIXEL_W-1:0]      wr_data,
   input  wire                              rd_en,
   input  wire [fsre_pkg::ADDR_W-1:0]       rd_addr,
   output logic [fsre_pkg::PIXEL_W-1:0]     rd_data
);

   logic [fsre_pkg::PIXEL_W-1:0] mem [fsre_pkg::DEPTH];
   logic [fsre_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/frame_scale_rotate_engine.sv
// ----------------------------------------------------------------------------
// frame_scale_rotate_engine
// Nearest-neighbor scale, quarter turn and mirror engine over a frame store.
// ----------------------------------------------------------------------------
// A command transfers at a rising edge with start high and busy low. A load
// writes one source pixel; loads may follow every cycle and busy stays low.
// A read keeps busy high until its pixel is out: in scale mode it runs two
// 16-step divisions on the shared restoring divider, then the address,
// memory read and output states; in the turn and mirror modes only the
// address, memory read and output states. The pixel appears on
// rsp_pixel_out with rsp_strobe for one cycle only, in the output state
// after the memory read; the receiver must take it then, it cannot stall.
// The frame store is not cleared at reset: read only what was loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_scale_rotate_engine (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_command,
   input  wire [fsre_pkg::PIXEL_W-1:0]         req_pixel_in,
   output logic                                rsp_strobe,
   output logic [fsre_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                                rsp_frame_last,
   input  wire                                 csr_wr_en,
   input  wire [fsre_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [fsre_pkg::SIZE_W-1:0]          csr_wr_data
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_ROW_GO   = 8'b0000_0010,
      ST_ROW_WAIT = 8'b0000_0100,
      ST_COL_GO   = 8'b0000_1000,
      ST_COL_WAIT = 8'b0001_0000,
      ST_ADDR     = 8'b0010_0000,
      ST_READ     = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   localparam int SW = fsre_pkg::SIZE_W;
   localparam int CW = fsre_pkg::COORD_W;
   localparam int AW = fsre_pkg::ADDR_W;

   state_type state_ff, state_in;

   logic [SW-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [SW-1:0] dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [fsre_pkg::MODE_W-1:0] mode_ff, mode_in;

   logic [AW-1:0] load_pos_ff, load_pos_in;
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;

   logic [CW-1:0] r_ff, r_in, c_ff, c_in;
   logic [CW-1:0] sr_ff, sr_in, sc_ff, sc_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          last_ff, last_in;

   logic [SW-1:0] sw, sh, ow, oh;
   logic [fsre_pkg::FRAME_W-1:0] frame_size;
   logic          accept, do_load, do_read;
   logic [AW-1:0] load_addr;
   logic [AW:0]   load_next;
   logic [CW-1:0] r_sel, c_sel;
   logic [SW-1:0] c_inc, r_inc;
   logic [SW-1:0] sw_m1, sh_m1;
   logic [CW+SW-1:0] row_prod, col_prod;
   logic [AW:0]   addr_sum;

   fsre_pkg::div_req_type div_req;
   fsre_pkg::div_rsp_type div_rsp;
   logic [fsre_pkg::PIXEL_W-1:0] rd_data;

   assign accept  = start && !busy;
   assign do_load = accept && (req_command == fsre_pkg::CMD_LOAD);
   assign do_read = accept && (req_command == fsre_pkg::CMD_READ);

   // effective sizes
   assign sw = fsre_pkg::clamp_size(src_w_ff, fsre_pkg::MAX_W_SIZE);
   assign sh = fsre_pkg::clamp_size(src_h_ff, fsre_pkg::MAX_H_SIZE);
   assign frame_size = fsre_pkg::FRAME_W'(sw) * fsre_pkg::FRAME_W'(sh);
   assign sw_m1 = sw - 1'b1;
   assign sh_m1 = sh - 1'b1;

   always_comb begin
      ow = sw;
      oh = sh;
      case (mode_ff)
         fsre_pkg::MODE_SCALE: begin
            ow = fsre_pkg::clamp_size(dst_w_ff, fsre_pkg::MAX_W_SIZE);
            oh = fsre_pkg::clamp_size(dst_h_ff, fsre_pkg::MAX_H_SIZE);
         end
         fsre_pkg::MODE_TURN_A, fsre_pkg::MODE_TURN_B: begin
            ow = sh;
            oh = sw;
         end
         default: begin
            ow = sw;
            oh = sh;
         end
      endcase
   end

   // configuration
   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      mode_in  = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fsre_pkg::CSR_SOURCE_WIDTH:  src_w_in = csr_wr_data;
            fsre_pkg::CSR_SOURCE_HEIGHT: src_h_in = csr_wr_data;
            fsre_pkg::CSR_TARGET_WIDTH:  dst_w_in = csr_wr_data;
            fsre_pkg::CSR_TARGET_HEIGHT: dst_h_in = csr_wr_data;
            fsre_pkg::CSR_TRANSFORM:     mode_in  = csr_wr_data[fsre_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // load position: restart at zero when it sits past the frame end
   assign load_addr = ({{(fsre_pkg::FRAME_W-AW){1'b0}}, load_pos_ff} >= frame_size)
                      ? '0 : load_pos_ff;
   assign load_next = {1'b0, load_addr} + 1'b1;
   always_comb begin
      load_pos_in = load_pos_ff;
      if (do_load) begin
         load_pos_in = ({{(fsre_pkg::FRAME_W-AW-1){1'b0}}, load_next} >= frame_size)
                       ? '0 : load_next[AW-1:0];
      end
   end

   // read position: restart when outside the output frame
   always_comb begin
      r_sel = row_ff;
      c_sel = col_ff;
      if (({1'b0, row_ff} >= oh) || ({1'b0, col_ff} >= ow)) begin
         r_sel = '0;
         c_sel = '0;
      end
   end
   assign c_inc = {1'b0, c_sel} + 1'b1;
   assign r_inc = {1'b0, r_sel} + 1'b1;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      last_in = last_ff;
      r_in    = r_ff;
      c_in    = c_ff;
      if (do_read) begin
         r_in    = r_sel;
         c_in    = c_sel;
         last_in = ({1'b0, r_sel} == (oh - 1'b1)) && ({1'b0, c_sel} == (ow - 1'b1));
         if (c_inc >= ow) begin
            col_in = '0;
            row_in = (r_inc >= oh) ? '0 : r_inc[CW-1:0];
         end else begin
            col_in = c_inc[CW-1:0];
            row_in = r_sel;
         end
      end
   end

   assign row_prod = (CW+SW)'(r_ff) * (CW+SW)'(sh);
   assign col_prod = (CW+SW)'(c_ff) * (CW+SW)'(sw);
   assign addr_sum = (AW+1)'(sr_ff) * (AW+1)'(sw) + (AW+1)'(sc_ff);

   always_comb begin
      div_req.start    = (state_ff == ST_ROW_GO) || (state_ff == ST_COL_GO);
      div_req.dividend = (state_ff == ST_COL_GO) ? col_prod[fsre_pkg::DIVIDEND_W-1:0]
                                                 : row_prod[fsre_pkg::DIVIDEND_W-1:0];
      div_req.divisor  = (state_ff == ST_COL_GO) ? ow : oh;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      sr_in    = sr_ff;
      sc_in    = sc_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_read) begin
               case (mode_ff)
                  fsre_pkg::MODE_SCALE: begin
                     sr_in = r_sel;
                     sc_in = c_sel;
                  end
                  fsre_pkg::MODE_TURN_A: begin
                     sr_in = c_sel;
                     sc_in = CW'(sw_m1 - {1'b0, r_sel});
                  end
                  fsre_pkg::MODE_TURN_B: begin
                     sr_in = CW'(sh_m1 - {1'b0, c_sel});
                     sc_in = r_sel;
                  end
                  fsre_pkg::MODE_MIRROR_LR: begin
                     sr_in = r_sel;
                     sc_in = CW'(sw_m1 - {1'b0, c_sel});
                  end
                  fsre_pkg::MODE_MIRROR_UD: begin
                     sr_in = CW'(sh_m1 - {1'b0, r_sel});
                     sc_in = c_sel;
                  end
                  default: begin
                     sr_in = r_sel;
                     sc_in = c_sel;
                  end
               endcase
               state_in = (mode_ff == fsre_pkg::MODE_SCALE) ? ST_ROW_GO : ST_ADDR;
            end
         end
         ST_ROW_GO: state_in = ST_ROW_WAIT;
         ST_ROW_WAIT: begin
            if (div_rsp.done) begin
               sr_in    = div_rsp.quotient[CW-1:0];
               state_in = ST_COL_GO;
            end
         end
         ST_COL_GO: state_in = ST_COL_WAIT;
         ST_COL_WAIT: begin
            if (div_rsp.done) begin
               sc_in    = div_rsp.quotient[CW-1:0];
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            addr_in  = addr_sum[AW-1:0];
            state_in = ST_READ;
         end
         ST_READ: state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         src_w_ff    <= fsre_pkg::SIZE_RESET;
         src_h_ff    <= fsre_pkg::SIZE_RESET;
         dst_w_ff    <= fsre_pkg::SIZE_RESET;
         dst_h_ff    <= fsre_pkg::SIZE_RESET;
         mode_ff     <= fsre_pkg::MODE_SCALE;
         load_pos_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         src_w_ff    <= src_w_in;
         src_h_ff    <= src_h_in;
         dst_w_ff    <= dst_w_in;
         dst_h_ff    <= dst_h_in;
         mode_ff     <= mode_in;
         load_pos_ff <= load_pos_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      c_ff    <= c_in;
      sr_ff   <= sr_in;
      sc_ff   <= sc_in;
      addr_ff <= addr_in;
      last_ff <= last_in;
   end

   fsre_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fsre_frame_store u_store (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (load_addr),
      .wr_data (req_pixel_in),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = (state_ff == ST_OUT);
   assign rsp_pixel_out  = rd_data;
   assign rsp_frame_last = last_ff;

   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_READ))
      else $error("result strobe without a preceding memory read");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_read_sets_busy: assert property (@(posedge clock) disable iff (reset)
      do_read |=> busy)
      else $error("read transfer did not raise busy");

   a_load_keeps_idle: assert property (@(posedge clock) disable iff (reset)
      do_load |=> !busy)
      else $error("load transfer left the engine busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == ST_ROW_WAIT) || (state_ff == ST_COL_WAIT)))
      else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
